// File: src/dskf_pkg.sv
// ----------------------------------------------------------------------------
// dskf_pkg
// Shared types, constants and byte helpers for the sort-key filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dskf_pkg;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_GBK    = 2'd1,
    MODE_BIG5   = 2'd2,
    MODE_UTF16  = 2'd3
  } mode_t;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_FOLD  = 2'd1;
  localparam logic [1:0] REG_ALNUM = 2'd2;

  localparam logic [15:0] GBK_PAIR_LO  = 16'h8140;
  localparam logic [15:0] GBK_PAIR_HI  = 16'hfefe;
  localparam logic [7:0]  GBK_LEAD_LO  = 8'h81;
  localparam logic [7:0]  GBK_LEAD_HI  = 8'hfe;
  localparam logic [7:0]  BYTE_FF      = 8'hff;
  localparam logic [7:0]  BIG5_LEAD_LO = 8'ha1;
  localparam logic [7:0]  BIG5_LEAD_HI = 8'hf9;
  localparam logic [7:0]  BIG5_TR1_LO  = 8'h40;
  localparam logic [7:0]  BIG5_TR1_HI  = 8'h7e;
  localparam logic [7:0]  BIG5_TR2_LO  = 8'ha1;
  localparam logic [7:0]  BIG5_TR2_HI  = 8'hfe;
  localparam logic [7:0]  ASCII_MAX    = 8'd127;
  localparam logic [7:0]  CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       end_of_key;
    logic       odd_length_error;
  } result_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] value;
  } single_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic single_t keep_single(input logic [7:0] c, input logic fold,
                                          input logic alnum);
    single_t r;
    logic    an;
    an = is_upper(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
         ((c >= 8'h30) && (c <= 8'h39));
    r.value = c;
    r.keep  = 1'b1;
    if (fold && is_upper(c)) begin
      r.value = c + CASE_OFFSET;
    end else if (alnum && !an && (c <= ASCII_MAX)) begin
      r.keep = 1'b0;
    end
    return r;
  endfunction

  function automatic logic pair_ok(input mode_t m, input logic [7:0] lead,
                                   input logic [7:0] trail);
    logic [15:0] v;
    logic        ok;
    v  = {lead, trail};
    ok = 1'b0;
    unique case (m)
      MODE_GBK:  ok = (v > GBK_PAIR_LO) && (v < GBK_PAIR_HI) && (trail != BYTE_FF);
      MODE_BIG5: ok = (lead >= BIG5_LEAD_LO) && (lead <= BIG5_LEAD_HI) &&
                      (((trail >= BIG5_TR1_LO) && (trail <= BIG5_TR1_HI)) ||
                       ((trail >= BIG5_TR2_LO) && (trail <= BIG5_TR2_HI)));
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic lead_ok(input mode_t m, input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    unique case (m)
      MODE_GBK:  ok = (b >= GBK_LEAD_LO) && (b <= GBK_LEAD_HI);
      MODE_BIG5: ok = (b >= BIG5_LEAD_LO) && (b <= BIG5_LEAD_HI);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: src/dictionary_sort_key_filter.sv
// ----------------------------------------------------------------------------
// dictionary_sort_key_filter
// Turns the raw bytes of a dictionary key into the bytes of its sort key.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid in_ready in_byte last_byte            | in
//  out     | out_valid out_ready key_byte byte_valid        | out
//          | end_of_key odd_length_error                    |
//  cfg     | cfg_write cfg_index cfg_data                   | in
//
//  One input byte per cycle while in_ready is high; each request yields zero
//  to two results, which enter a four-entry result queue and leave one per
//  cycle while out_ready is high. in_ready is high while the queue has at
//  least two free entries, so input stalls whenever results build up.
//  Reset clears the held byte, the queue and the registers to their
//  defaults. A stalled output fills the queue and then holds off input.
// ----------------------------------------------------------------------------
`default_nettype none

module dictionary_sort_key_filter
  import dskf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      key_byte,
  output logic            byte_valid,
  output logic            end_of_key,
  output logic            odd_length_error,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  mode_t      encoding_mode;
  logic       lower_en;
  logic       alnum_only;

  logic [7:0] held_byte;
  logic       held_valid;

  result_t    q [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;

  logic       accept;
  logic       pop;
  result_t    e0;
  result_t    e1;
  logic [1:0] n;
  logic       hold_new;
  logic       held_valid_next;
  logic       err;
  logic       consumed;
  single_t    s_held;
  single_t    s_in;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= 3'd2);
  assign out_valid = (count != 3'd0);

  assign key_byte         = q[rd_ptr].key_byte;
  assign byte_valid       = q[rd_ptr].byte_valid;
  assign end_of_key       = q[rd_ptr].end_of_key;
  assign odd_length_error = q[rd_ptr].odd_length_error;

  assign s_held = keep_single(held_byte, lower_en, alnum_only);
  assign s_in   = keep_single(in_byte, lower_en, alnum_only);

  always_comb begin
    e0              = '0;
    e1              = '0;
    n               = 2'd0;
    hold_new        = 1'b0;
    held_valid_next = held_valid;
    err             = 1'b0;
    consumed        = 1'b0;
    if (encoding_mode == MODE_UTF16) begin
      if (held_valid) begin
        held_valid_next = 1'b0;
        if (in_byte == 8'd0) begin
          // unit fits in one byte: fold and filter it
          if (s_held.keep) begin
            e0 = '{key_byte: s_held.value, byte_valid: 1'b1, default: 1'b0};
            e1 = '{key_byte: 8'd0, byte_valid: 1'b1, default: 1'b0};
            n  = 2'd2;
          end
        end else begin
          e0 = '{key_byte: held_byte, byte_valid: 1'b1, default: 1'b0};
          e1 = '{key_byte: in_byte, byte_valid: 1'b1, default: 1'b0};
          n  = 2'd2;
        end
      end else if (!last_byte) begin
        hold_new        = 1'b1;
        held_valid_next = 1'b1;
      end else begin
        err = 1'b1;
      end
    end else begin
      if (held_valid) begin
        held_valid_next = 1'b0;
        if (pair_ok(encoding_mode, held_byte, in_byte)) begin
          e0       = '{key_byte: held_byte, byte_valid: 1'b1, default: 1'b0};
          e1       = '{key_byte: in_byte, byte_valid: 1'b1, default: 1'b0};
          n        = 2'd2;
          consumed = 1'b1;
        end else if (s_held.keep) begin
          e0 = '{key_byte: s_held.value, byte_valid: 1'b1, default: 1'b0};
          n  = 2'd1;
        end
      end
      if (!consumed) begin
        if (!last_byte && lead_ok(encoding_mode, in_byte)) begin
          hold_new        = 1'b1;
          held_valid_next = 1'b1;
        end else if (s_in.keep) begin
          if (n == 2'd0) begin
            e0 = '{key_byte: s_in.value, byte_valid: 1'b1, default: 1'b0};
          end else begin
            e1 = '{key_byte: s_in.value, byte_valid: 1'b1, default: 1'b0};
          end
          n = n + 2'd1;
        end
      end
    end
    if (last_byte) begin
      held_valid_next = 1'b0;
      hold_new        = 1'b0;
      // mark the final result, or give a bare end marker
      priority case (n)
        2'd0: begin
          e0 = '{end_of_key: 1'b1, odd_length_error: err, default: '0};
          n  = 2'd1;
        end
        2'd1: begin
          e0.end_of_key       = 1'b1;
          e0.odd_length_error = err;
        end
        default: begin
          e1.end_of_key       = 1'b1;
          e1.odd_length_error = err;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= MODE_SINGLE;
      lower_en      <= 1'b1;
      alnum_only    <= 1'b0;
      held_valid    <= 1'b0;
      held_byte     <= 8'd0;
      rd_ptr        <= 2'd0;
      wr_ptr        <= 2'd0;
      count         <= 3'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MODE:  encoding_mode <= mode_t'(cfg_data);
          REG_FOLD:  lower_en      <= cfg_data[0];
          REG_ALNUM: alnum_only    <= cfg_data[0];
          default:   ;
        endcase
      end
      if (accept) begin
        held_valid <= held_valid_next;
        if (hold_new) begin
          held_byte <= in_byte;
        end
        wr_ptr <= wr_ptr + n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? 3'(n) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (n != 2'd0) begin
        q[wr_ptr] <= e0;
      end
      if (n == 2'd2) begin
        q[wr_ptr + 2'd1] <= e1;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_last_gives_result : assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> out_valid)
    else $error("end of key produced no result");

  a_last_clears_hold : assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> !held_valid)
    else $error("byte still held after end of key");

  a_end_has_error_only_at_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && odd_length_error |-> end_of_key && !byte_valid)
    else $error("odd length flag outside bare end marker");

endmodule

`default_nettype wire
